[rtl/dfa_token_scanner_core_macros.svh]
// Assertion helpers for the token scanner. All checks are clocked on clk_i and
// are held off while rst_ni is low.
`ifndef DFA_TOKEN_SCANNER_CORE_MACROS_SVH
`define DFA_TOKEN_SCANNER_CORE_MACROS_SVH
`ifndef SYNTH
`define DTS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`define DTS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");
`define DTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define DTS_ASSERT_NEVER(lbl, cond)
`define DTS_ASSERT_IMPLY(lbl, ante, cons)
`define DTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/dts_pkg.sv]
package dts_pkg;

  localparam int NUM_W      = 31;
  localparam int KW_CHARS   = 8;
  localparam int KW_W       = 8 * KW_CHARS;
  localparam int KW_IDX_W   = $clog2(KW_CHARS);
  localparam int KW_COUNT   = 11;
  localparam int QD         = 4;
  localparam int QA_W       = $clog2(QD);

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  typedef enum logic [4:0] {
    KIND_LBRACE      = 5'd0,
    KIND_RBRACE      = 5'd1,
    KIND_LPAREN      = 5'd2,
    KIND_RPAREN      = 5'd3,
    KIND_COMMA       = 5'd4,
    KIND_SEMI        = 5'd5,
    KIND_MINUS       = 5'd6,
    KIND_PLUS        = 5'd7,
    KIND_PLUS_ASSIGN = 5'd8,
    KIND_ASSIGN      = 5'd9,
    KIND_EQUAL       = 5'd10,
    KIND_AND         = 5'd11,
    KIND_NUMBER      = 5'd12,
    KIND_IDENT       = 5'd13,
    KIND_STRING      = 5'd14,
    KIND_KW_BOOLEAN  = 5'd15,
    KIND_KW_FOR      = 5'd16,
    KIND_KW_FUNCTION = 5'd17,
    KIND_KW_IF       = 5'd18,
    KIND_KW_INPUT    = 5'd19,
    KIND_KW_OUTPUT   = 5'd20,
    KIND_KW_RETURN   = 5'd21,
    KIND_KW_STRING   = 5'd22,
    KIND_KW_VAR      = 5'd23,
    KIND_KW_VOID     = 5'd24,
    KIND_KW_INT      = 5'd25,
    KIND_END         = 5'd26,
    KIND_TEXT        = 5'd27,
    KIND_ERROR       = 5'd28
  } kind_e;

  typedef enum logic [2:0] {
    ERR_LONE_AMP      = 3'd0,
    ERR_OPEN_STRING   = 3'd1,
    ERR_LONE_SLASH    = 3'd2,
    ERR_OPEN_COMMENT  = 3'd3,
    ERR_BAD_CHAR      = 3'd4,
    ERR_SLASH_NO_STAR = 3'd5
  } err_e;

  // Source characters the scanner reacts to.
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_BS         = 8'h08;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_0          = 8'h30;
  localparam logic [7:0] CH_9          = 8'h39;
  localparam logic [7:0] CH_LA         = 8'h61;
  localparam logic [7:0] CH_LZ         = 8'h7A;
  localparam logic [7:0] CH_UA         = 8'h41;
  localparam logic [7:0] CH_UZ         = 8'h5A;

  // Keyword spellings, first character in the lowest byte, zero padded.
  localparam logic [KW_W-1:0] KW_TEXT [KW_COUNT] = '{
    KW_W'(64'h006E_6165_6C6F_6F62),  // boolean
    KW_W'(64'h0000_0000_0072_6F66),  // for
    KW_W'(64'h6E6F_6974_636E_7566),  // function
    KW_W'(64'h0000_0000_0000_6669),  // if
    KW_W'(64'h0000_0074_7570_6E69),  // input
    KW_W'(64'h0000_7475_7074_756F),  // output
    KW_W'(64'h0000_6E72_7574_6572),  // return
    KW_W'(64'h0000_676E_6972_7473),  // string
    KW_W'(64'h0000_0000_0072_6176),  // var
    KW_W'(64'h0000_0000_6469_6F76),  // void
    KW_W'(64'h0000_0000_0074_6E69)   // int
  };
  localparam int KW_LEN [KW_COUNT] = '{7, 3, 8, 2, 5, 6, 6, 6, 3, 4, 3};

  typedef struct packed {
    kind_e             kind;
    logic [NUM_W-1:0]  num;
    logic [7:0]        text;
    logic [2:0]        err;
    logic [31:0]       line;
    logic [15:0]       off;
  } res_t;

  // All results caused by one source word; cnt is 0, 1 or 2.
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [1:0]       res;
  } bun_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // The window beyond the word length is always zero, so a full-width compare
  // together with the length check matches the keyword exactly.
  function automatic kind_e kw_lookup(logic [KW_W-1:0] win, logic [3:0] len);
    kind_e kind;
    kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (KW_LEN[k] <= KW_CHARS && len == 4'(KW_LEN[k]) && win == KW_TEXT[k]) begin
        kind = kind_e'(5'(KIND_KW_BOOLEAN) + 5'(k));
      end
    end
    return kind;
  endfunction

endpackage

[rtl/dfa_token_scanner_core.sv]
// Lexical scanner that takes one source byte per word (or an end-of-input mark)
// and returns tokens, streamed identifier and string characters, error codes,
// the current line and an identifier/keyword offset. Both sides behave as a
// queue: a byte is taken when push is high and full is low, and a result is
// taken when pop is high and empty is low. The scanner state machine handles
// one byte per clock while full is low, so bytes can be pushed back to back;
// each byte gives zero, one or two results, and those go through a four-entry
// queue to an output register that hands out one result per clock while pop is
// high. A sustained stream therefore runs at one byte per cycle while bytes
// average at most one result, and the output port sets the pace otherwise. A
// result passes through the queue and then the output register before it shows
// on the ports. The last result of each byte carries last_o. After the end mark
// every further byte returns a single end token.
`include "dfa_token_scanner_core_macros.svh"

module dfa_token_scanner_core import dts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_input_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  token_kind_o,
  output logic [30:0] number_value_o,
  output logic [7:0]  text_byte_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] line_number_o,
  output logic [15:0] name_offset_o,
  output logic        last_o
);

  logic    accept;
  bun_t    front_bun;
  bun_t    q_rdata;
  q_stat_t q_stat;
  logic    q_pop;
  res_t    res;

  // A byte is taken only when the queue has room for its results.
  assign full   = q_stat.full;
  assign accept = push && !full;

  dts_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_byte_i    (char_byte_i),
    .end_of_input_i (end_of_input_i),
    .bun_o          (front_bun)
  );

  // Bytes that give no result, such as blanks and comment text, leave no entry.
  dts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && (front_bun.cnt != 2'd0)),
    .wdata_i (front_bun),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  dts_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_rdata_i (q_rdata),
    .q_stat_i  (q_stat),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res),
    .last_o    (last_o)
  );

  assign token_kind_o   = res.kind;
  assign number_value_o = res.num;
  assign text_byte_o    = res.text;
  assign error_code_o   = res.err;
  assign line_number_o  = res.line;
  assign name_offset_o  = res.off;

  // The queue can never report full and empty together.
  `DTS_ASSERT_NEVER(a_queue_status, q_stat.full && q_stat.empty)
  // The second result of a byte is ready right after the first one leaves.
  `DTS_ASSERT_NEXT(a_second_follows, pop && !empty && !last_o, !empty)
  // The end token always closes the results of its byte.
  `DTS_ASSERT_IMPLY(a_end_is_last, !empty && token_kind_o == KIND_END, last_o)

endmodule

[rtl/dts_front.sv]
module dts_front import dts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_input_i,
  output bun_t       bun_o
);

  typedef enum logic [3:0] {
    ST_START,
    ST_PLUS,
    ST_EQ,
    ST_AMP,
    ST_NUM,
    ST_WORD,
    ST_STR,
    ST_SLASH,
    ST_COM,
    ST_COMSTAR
  } state_e;

  state_e              state_q, state_d;
  logic [NUM_W-1:0]    acc_q, acc_d;
  logic [KW_W-1:0]     win_q, win_d;
  logic [3:0]          wlen_q, wlen_d;
  logic [31:0]         line_q, line_d;
  logic [15:0]         off_q, off_d;
  logic                fin_q, fin_d;

  logic                restart;
  logic [1:0]          n;
  res_t [1:0]          res;
  logic [NUM_W+3:0]    prod;
  logic                c_digit;
  logic                c_letter;

  function automatic res_t mk_res(kind_e k, logic [NUM_W-1:0] num, logic [7:0] txt,
                                  logic [2:0] err, logic [15:0] off, logic [31:0] line);
    res_t r;
    r.kind = k;
    r.num  = num;
    r.text = txt;
    r.err  = err;
    r.line = line;
    r.off  = off;
    return r;
  endfunction

  assign c_digit  = char_byte_i inside {[CH_0:CH_9]};
  assign c_letter = (char_byte_i inside {[CH_LA:CH_LZ]}) || (char_byte_i inside {[CH_UA:CH_UZ]});

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    win_d   = win_q;
    wlen_d  = wlen_q;
    line_d  = line_q;
    off_d   = off_q;
    fin_d   = fin_q;
    restart = 1'b0;
    n       = '0;
    res     = '0;
    prod    = (NUM_W+4)'(acc_q) * (NUM_W+4)'(10) + (NUM_W+4)'(char_byte_i - CH_0);

    if (fin_q) begin
      res[0] = mk_res(KIND_END, '0, '0, '0, '0, line_q);
      n      = 2'd1;
    end else if (end_of_input_i) begin
      case (state_q)
        ST_PLUS: begin
          res[0] = mk_res(KIND_PLUS, '0, '0, '0, '0, line_q);
          n      = 2'd1;
        end
        ST_EQ: begin
          res[0] = mk_res(KIND_ASSIGN, '0, '0, '0, '0, line_q);
          n      = 2'd1;
        end
        ST_AMP: begin
          res[0] = mk_res(KIND_ERROR, '0, '0, ERR_LONE_AMP, '0, line_q);
          n      = 2'd1;
        end
        ST_NUM: begin
          res[0] = mk_res(KIND_NUMBER, acc_q, '0, '0, '0, line_q);
          n      = 2'd1;
        end
        ST_WORD: begin
          res[0] = mk_res(kw_lookup(win_q, wlen_q), '0, '0, '0, off_q, line_q);
          n      = 2'd1;
          off_d  = off_q + 16'd1;
          wlen_d = '0;
          win_d  = '0;
        end
        ST_STR: begin
          res[0] = mk_res(KIND_ERROR, '0, '0, ERR_OPEN_STRING, '0, line_q);
          n      = 2'd1;
        end
        ST_SLASH: begin
          res[0] = mk_res(KIND_ERROR, '0, '0, ERR_LONE_SLASH, '0, line_q);
          n      = 2'd1;
        end
        ST_COM, ST_COMSTAR: begin
          res[0] = mk_res(KIND_ERROR, '0, '0, ERR_OPEN_COMMENT, '0, line_q);
          n      = 2'd1;
        end
        default: begin
        end
      endcase
      res[n[0]] = mk_res(KIND_END, '0, '0, '0, '0, line_q);
      n         = n + 2'd1;
      acc_d     = '0;
      state_d   = ST_START;
      fin_d     = 1'b1;
    end else begin
      // First look at the byte in the current state. A token that the byte
      // closes without using it sends the byte back through the start state.
      case (state_q)
        ST_START: begin
          restart = 1'b1;
        end
        ST_PLUS: begin
          state_d = ST_START;
          if (char_byte_i == CH_EQ) begin
            res[0] = mk_res(KIND_PLUS_ASSIGN, '0, '0, '0, '0, line_q);
          end else begin
            res[0]  = mk_res(KIND_PLUS, '0, '0, '0, '0, line_q);
            restart = 1'b1;
          end
          n = 2'd1;
        end
        ST_EQ: begin
          state_d = ST_START;
          if (char_byte_i == CH_EQ) begin
            res[0] = mk_res(KIND_EQUAL, '0, '0, '0, '0, line_q);
          end else begin
            res[0]  = mk_res(KIND_ASSIGN, '0, '0, '0, '0, line_q);
            restart = 1'b1;
          end
          n = 2'd1;
        end
        ST_AMP: begin
          state_d = ST_START;
          if (char_byte_i == CH_AMP) begin
            res[0] = mk_res(KIND_AND, '0, '0, '0, '0, line_q);
          end else begin
            res[0]  = mk_res(KIND_ERROR, '0, '0, ERR_LONE_AMP, '0, line_q);
            restart = 1'b1;
          end
          n = 2'd1;
        end
        ST_NUM: begin
          if (c_digit) begin
            acc_d = (prod > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : prod[NUM_W-1:0];
          end else begin
            res[0]  = mk_res(KIND_NUMBER, acc_q, '0, '0, '0, line_q);
            n       = 2'd1;
            acc_d   = '0;
            state_d = ST_START;
            restart = 1'b1;
          end
        end
        ST_WORD: begin
          if (c_letter || c_digit || char_byte_i == CH_UNDERSCORE) begin
            if (32'(wlen_q) < KW_CHARS) begin
              win_d[8*wlen_q[KW_IDX_W-1:0] +: 8] = char_byte_i;
            end
            if (wlen_q != 4'hF) begin
              wlen_d = wlen_q + 4'd1;
            end
            res[0] = mk_res(KIND_TEXT, '0, char_byte_i, '0, '0, line_q);
            n      = 2'd1;
          end else begin
            res[0]  = mk_res(kw_lookup(win_q, wlen_q), '0, '0, '0, off_q, line_q);
            n       = 2'd1;
            off_d   = off_q + 16'd1;
            wlen_d  = '0;
            win_d   = '0;
            state_d = ST_START;
            restart = 1'b1;
          end
        end
        ST_STR: begin
          if (char_byte_i == CH_QUOTE) begin
            res[0]  = mk_res(KIND_STRING, '0, '0, '0, '0, line_q);
            state_d = ST_START;
          end else begin
            res[0] = mk_res(KIND_TEXT, '0, char_byte_i, '0, '0, line_q);
          end
          n = 2'd1;
        end
        ST_SLASH: begin
          if (char_byte_i == CH_STAR) begin
            state_d = ST_COM;
          end else begin
            res[0]  = mk_res(KIND_ERROR, '0, '0, ERR_SLASH_NO_STAR, '0, line_q);
            n       = 2'd1;
            state_d = ST_START;
          end
        end
        ST_COM: begin
          if (char_byte_i == CH_STAR) begin
            state_d = ST_COMSTAR;
          end
        end
        ST_COMSTAR: begin
          if (char_byte_i == CH_SLASH) begin
            state_d = ST_START;
          end else if (char_byte_i != CH_STAR) begin
            state_d = ST_COM;
          end
        end
        default: begin
          state_d = ST_START;
          restart = 1'b1;
        end
      endcase

      if (restart) begin
        state_d = ST_START;
        case (char_byte_i)
          CH_LBRACE: begin
            res[n[0]] = mk_res(KIND_LBRACE, '0, '0, '0, '0, line_q);
            n         = n + 2'd1;
          end
          CH_RBRACE: begin
            res[n[0]] = mk_res(KIND_RBRACE, '0, '0, '0, '0, line_q);
            n         = n + 2'd1;
          end
          CH_LPAREN: begin
            res[n[0]] = mk_res(KIND_LPAREN, '0, '0, '0, '0, line_q);
            n         = n + 2'd1;
          end
          CH_RPAREN: begin
            res[n[0]] = mk_res(KIND_RPAREN, '0, '0, '0, '0, line_q);
            n         = n + 2'd1;
          end
          CH_COMMA: begin
            res[n[0]] = mk_res(KIND_COMMA, '0, '0, '0, '0, line_q);
            n         = n + 2'd1;
          end
          CH_SEMI: begin
            res[n[0]] = mk_res(KIND_SEMI, '0, '0, '0, '0, line_q);
            n         = n + 2'd1;
          end
          CH_MINUS: begin
            res[n[0]] = mk_res(KIND_MINUS, '0, '0, '0, '0, line_q);
            n         = n + 2'd1;
          end
          CH_PLUS:  state_d = ST_PLUS;
          CH_EQ:    state_d = ST_EQ;
          CH_AMP:   state_d = ST_AMP;
          CH_SLASH: state_d = ST_SLASH;
          CH_QUOTE: state_d = ST_STR;
          CH_LF, CH_SPACE, CH_TAB, CH_NUL, CH_BS, CH_CR: begin
          end
          default: begin
            if (c_digit) begin
              acc_d   = NUM_W'(char_byte_i - CH_0);
              state_d = ST_NUM;
            end else if (c_letter) begin
              win_d       = '0;
              win_d[7:0]  = char_byte_i;
              wlen_d      = 4'd1;
              res[n[0]]   = mk_res(KIND_TEXT, '0, char_byte_i, '0, '0, line_q);
              n           = n + 2'd1;
              state_d     = ST_WORD;
            end else begin
              res[n[0]] = mk_res(KIND_ERROR, '0, '0, ERR_BAD_CHAR, '0, line_q);
              n         = n + 2'd1;
            end
          end
        endcase
      end

      // A newline counts only after the results of its own word.
      if (char_byte_i == CH_LF && line_q != 32'hFFFF_FFFF) begin
        line_d = line_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      acc_q   <= '0;
      win_q   <= '0;
      wlen_q  <= '0;
      line_q  <= 32'd1;
      off_q   <= '0;
      fin_q   <= 1'b0;
    end else if (accept_i) begin
      state_q <= state_d;
      acc_q   <= acc_d;
      win_q   <= win_d;
      wlen_q  <= wlen_d;
      line_q  <= line_d;
      off_q   <= off_d;
      fin_q   <= fin_d;
    end
  end

  assign bun_o.cnt = n;
  assign bun_o.res = res;

endmodule

[rtl/dts_queue.sv]
module dts_queue import dts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bun_t    wdata_i,
  input  logic    pop_i,
  output bun_t    rdata_o,
  output q_stat_t stat_o
);

  bun_t            entries_q [QD];
  logic [QA_W-1:0] wr_q;
  logic [QA_W-1:0] rd_q;
  logic [QA_W:0]   cnt_q;
  logic            do_push;
  logic            do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (QA_W+1)'(QD));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = entries_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QA_W'(QD - 1)) ? '0 : wr_q + QA_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QA_W'(QD - 1)) ? '0 : rd_q + QA_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QA_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QA_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_q] <= wdata_i;
    end
  end

endmodule

[rtl/dts_back.sv]
module dts_back import dts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  bun_t    q_rdata_i,
  input  q_stat_t q_stat_i,
  output logic    q_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output res_t    res_o,
  output logic    last_o
);

  logic vld_q;
  logic idx_q;
  bun_t bun_q;
  logic load;

  assign last_o  = idx_q || (bun_q.cnt == 2'd1);
  assign empty_o = !vld_q;
  assign res_o   = bun_q.res[idx_q];

  // Refill the output register when it is free or its final result leaves.
  assign load    = !vld_q || (pop_i && last_o);
  assign q_pop_o = load && !q_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 1'b0;
    end else if (load) begin
      vld_q <= !q_stat_i.empty;
      idx_q <= 1'b0;
    end else if (pop_i) begin
      idx_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bun_q <= q_rdata_i;
    end
  end

endmodule
